// ===== design/fwicp_pkg.sv =====
package fwicp_pkg;

  // Table and stream geometry
  localparam int MAX_CHUNKS = 32;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int POS_W      = 32;

  localparam logic [31:0] IMG_MAGIC = 32'h4657_5452;

  // Header byte positions
  localparam logic [POS_W-1:0] HDR_BYTES    = POS_W'(16);
  localparam logic [POS_W-1:0] POS_MAGIC    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_COUNT    = POS_W'(11);

  // Chunk header byte counter marks
  localparam logic [2:0] CHDR_OFFSET = 3'd0;
  localparam logic [2:0] CHDR_ADDR   = 3'd3;
  localparam logic [2:0] CHDR_LAST   = 3'd7;

  // Operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Parse status / error codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_MAGIC      = 3'd2;
  localparam logic [2:0] ST_COUNT      = 3'd3;
  localparam logic [2:0] ST_HDR_TRUNC  = 3'd4;
  localparam logic [2:0] ST_DATA_TRUNC = 3'd5;
  localparam logic [2:0] ST_TOO_LONG   = 3'd6;

  // Query status codes
  localparam logic [2:0] QST_OK        = 3'd0;
  localparam logic [2:0] QST_BAD_INDEX = 3'd1;

  // One chunk table entry
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] addr;
    logic [31:0] len;
  } chunk_entry_t;

endpackage

// ===== design/fwicp_in_if.sv =====
interface fwicp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       last;
  logic [7:0] chunk_index;

  modport source (output valid, output op, output data_byte, output last,
                  output chunk_index, input ready);
  modport sink (input valid, input op, input data_byte, input last,
                input chunk_index, output ready);
endinterface

// ===== design/fwicp_out_if.sv =====
interface fwicp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [31:0] version;
  logic [5:0]  chunk_count;
  logic        image_nonzero;
  logic [31:0] chunk_addr;
  logic [31:0] chunk_len;
  logic [31:0] chunk_offset;

  modport source (output valid, output kind, output status, output version,
                  output chunk_count, output image_nonzero, output chunk_addr,
                  output chunk_len, output chunk_offset, input ready);
  modport sink (input valid, input kind, input status, input version,
                input chunk_count, input image_nonzero, input chunk_addr,
                input chunk_len, input chunk_offset, output ready);
endinterface

// ===== design/firmware_image_chunk_parser_top.sv =====
// A last byte or a query shows its result through the result stage and then the output register.
// Throughput: one item per cycle while the result stage is empty or can advance; the chunk table
// read for a query is registered, and each byte updates the parse state.
// Reset (rst, synchronous, active high) clears the parse state, valid chunk count
// and the pipeline; the chunk table is not cleared and only entries written by
// the last good image are ever read.
module firmware_image_chunk_parser_top (
  input  logic              clk,
  input  logic              rst,
  fwicp_in_if.sink          in_ch,
  fwicp_out_if.source       out_ch
);

  // Parse state
  logic [fwicp_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]                 word_assembler, word_assembler_next;
  logic [31:0]                 image_version, image_version_next;
  logic [fwicp_pkg::CNT_W-1:0] declared_chunks, declared_chunks_next;
  logic [fwicp_pkg::CNT_W-1:0] chunk_cursor, chunk_cursor_next;
  logic                        in_chunk_data, in_chunk_data_next;
  logic [2:0]                  header_byte_count, header_byte_count_next;
  logic [31:0]                 data_remaining, data_remaining_next;
  logic [2:0]                  error_code, error_code_next;
  logic                        nonzero_seen, nonzero_seen_next;
  logic [fwicp_pkg::CNT_W-1:0] valid_chunks, valid_chunks_next;
  logic [31:0]                 hdr_offset, hdr_offset_next;
  logic [31:0]                 hdr_addr, hdr_addr_next;

  // Chunk table
  fwicp_pkg::chunk_entry_t     chunk_mem [fwicp_pkg::MAX_CHUNKS];
  fwicp_pkg::chunk_entry_t     rd_entry;
  logic                        mem_we;

  // Result stage and output register
  logic                        s1_valid;
  logic                        s1_kind;
  logic [2:0]                  s1_status;
  logic [31:0]                 s1_version;
  logic [fwicp_pkg::CNT_W-1:0] s1_count;
  logic                        s1_nonzero;
  logic                        s1_hit;
  logic                        s1_adv;
  logic                        s1_load;
  logic                        out_valid;

  // Combinational per-item values
  logic                        acc;
  logic                        is_byte;
  logic [2:0]                  rpt_status;
  logic                        q_hit;
  logic [fwicp_pkg::POS_W-1:0] pos_inc;
  logic [31:0]                 dr_dec;

  assign acc     = in_ch.valid && in_ch.ready;
  assign is_byte = (in_ch.op == fwicp_pkg::OP_BYTE);
  assign s1_adv  = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign s1_load = acc && (!is_byte || in_ch.last);
  assign q_hit   = in_ch.chunk_index < 8'(valid_chunks);
  assign pos_inc = byte_position + fwicp_pkg::POS_W'(1);
  assign dr_dec  = data_remaining - 32'd1;

  // Advance the parse state for one image byte
  always_comb begin
    byte_position_next     = byte_position;
    word_assembler_next    = word_assembler;
    image_version_next     = image_version;
    declared_chunks_next   = declared_chunks;
    chunk_cursor_next      = chunk_cursor;
    in_chunk_data_next     = in_chunk_data;
    header_byte_count_next = header_byte_count;
    data_remaining_next    = data_remaining;
    error_code_next        = error_code;
    nonzero_seen_next      = nonzero_seen;
    valid_chunks_next      = valid_chunks;
    hdr_offset_next        = hdr_offset;
    hdr_addr_next          = hdr_addr;
    mem_we                 = 1'b0;
    rpt_status             = fwicp_pkg::ST_OK;

    if (acc && is_byte) begin
      if (byte_position == '0 && error_code != fwicp_pkg::ST_TOO_LONG) begin
        valid_chunks_next = '0;
      end
      if (in_ch.data_byte != 8'd0) begin
        nonzero_seen_next = 1'b1;
      end
      word_assembler_next = {in_ch.data_byte, word_assembler[31:8]};

      if (error_code == fwicp_pkg::ST_OK) begin
        if (byte_position < fwicp_pkg::HDR_BYTES) begin
          // Image header fields
          if (byte_position == fwicp_pkg::POS_MAGIC &&
              word_assembler_next != fwicp_pkg::IMG_MAGIC) begin
            error_code_next = fwicp_pkg::ST_MAGIC;
          end else if (byte_position == fwicp_pkg::POS_VERSION) begin
            image_version_next = word_assembler_next;
          end else if (byte_position == fwicp_pkg::POS_COUNT) begin
            if (word_assembler_next > 32'(fwicp_pkg::MAX_CHUNKS)) begin
              error_code_next = fwicp_pkg::ST_COUNT;
            end else begin
              declared_chunks_next = word_assembler_next[fwicp_pkg::CNT_W-1:0];
            end
          end
        end else if (chunk_cursor < declared_chunks) begin
          if (in_chunk_data) begin
            // Count down chunk data
            data_remaining_next = dr_dec;
            if (dr_dec == 32'd0) begin
              in_chunk_data_next = 1'b0;
              chunk_cursor_next  = chunk_cursor + fwicp_pkg::CNT_W'(1);
            end
          end else begin
            // Collect the chunk header, write the entry on its last byte
            if (header_byte_count == fwicp_pkg::CHDR_OFFSET) begin
              hdr_offset_next = 32'(byte_position);
            end
            if (header_byte_count == fwicp_pkg::CHDR_ADDR) begin
              hdr_addr_next = word_assembler_next;
            end
            if (header_byte_count == fwicp_pkg::CHDR_LAST) begin
              mem_we                 = 1'b1;
              header_byte_count_next = 3'd0;
              if (word_assembler_next == 32'd0) begin
                chunk_cursor_next = chunk_cursor + fwicp_pkg::CNT_W'(1);
              end else begin
                in_chunk_data_next  = 1'b1;
                data_remaining_next = word_assembler_next;
              end
            end else begin
              header_byte_count_next = header_byte_count + 3'd1;
            end
          end
        end
      end

      byte_position_next = pos_inc;
      if (pos_inc == '0) begin
        error_code_next = fwicp_pkg::ST_TOO_LONG;
      end

      // Report and restart the stream on the last byte
      if (in_ch.last) begin
        if (error_code_next == fwicp_pkg::ST_TOO_LONG) begin
          rpt_status = fwicp_pkg::ST_TOO_LONG;
        end else if (byte_position_next < fwicp_pkg::HDR_BYTES) begin
          rpt_status = fwicp_pkg::ST_SHORT;
        end else if (error_code_next != fwicp_pkg::ST_OK) begin
          rpt_status = error_code_next;
        end else if (chunk_cursor_next < declared_chunks_next) begin
          rpt_status = in_chunk_data_next ? fwicp_pkg::ST_DATA_TRUNC
                                          : fwicp_pkg::ST_HDR_TRUNC;
        end else begin
          rpt_status = fwicp_pkg::ST_OK;
        end
        valid_chunks_next = (rpt_status == fwicp_pkg::ST_OK) ? declared_chunks_next : '0;
      end
    end
  end

  // Update parse state
  always_ff @(posedge clk) begin
    if (rst || (acc && is_byte && in_ch.last)) begin
      byte_position     <= '0;
      word_assembler    <= '0;
      image_version     <= '0;
      declared_chunks   <= '0;
      chunk_cursor      <= '0;
      in_chunk_data     <= 1'b0;
      header_byte_count <= '0;
      data_remaining    <= '0;
      error_code        <= fwicp_pkg::ST_OK;
      nonzero_seen      <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      word_assembler    <= word_assembler_next;
      image_version     <= image_version_next;
      declared_chunks   <= declared_chunks_next;
      chunk_cursor      <= chunk_cursor_next;
      in_chunk_data     <= in_chunk_data_next;
      header_byte_count <= header_byte_count_next;
      data_remaining    <= data_remaining_next;
      error_code        <= error_code_next;
      nonzero_seen      <= nonzero_seen_next;
    end
    if (rst) begin
      valid_chunks <= '0;
    end else begin
      valid_chunks <= valid_chunks_next;
    end
    hdr_offset <= hdr_offset_next;
    hdr_addr   <= hdr_addr_next;
  end

  // Chunk table: write on the last chunk header byte, read on a query
  always_ff @(posedge clk) begin
    if (mem_we) begin
      chunk_mem[chunk_cursor[fwicp_pkg::IDX_W-1:0]] <=
        '{offset: hdr_offset, addr: hdr_addr, len: word_assembler_next};
    end
    if (acc && !is_byte) begin
      rd_entry <= chunk_mem[in_ch.chunk_index[fwicp_pkg::IDX_W-1:0]];
    end
  end

  // Result stage: hold while the output register is full and not taken
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (s1_load) begin
      if (is_byte) begin
        s1_kind    <= fwicp_pkg::KIND_REPORT;
        s1_status  <= rpt_status;
        s1_version <= (rpt_status == fwicp_pkg::ST_OK) ? image_version_next : 32'd0;
        s1_count   <= valid_chunks_next;
        s1_nonzero <= nonzero_seen_next;
        s1_hit     <= 1'b0;
      end else begin
        s1_kind    <= fwicp_pkg::KIND_QUERY;
        s1_status  <= q_hit ? fwicp_pkg::QST_OK : fwicp_pkg::QST_BAD_INDEX;
        s1_version <= 32'd0;
        s1_count   <= valid_chunks;
        s1_nonzero <= 1'b0;
        s1_hit     <= q_hit;
      end
    end
  end

  // Output register: merge table data for a query hit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_adv) begin
      out_ch.kind          <= s1_kind;
      out_ch.status        <= s1_status;
      out_ch.version       <= s1_version;
      out_ch.chunk_count   <= 6'(s1_count);
      out_ch.image_nonzero <= s1_nonzero;
      out_ch.chunk_addr    <= s1_hit ? rd_entry.addr   : 32'd0;
      out_ch.chunk_len     <= s1_hit ? rd_entry.len    : 32'd0;
      out_ch.chunk_offset  <= s1_hit ? rd_entry.offset : 32'd0;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== dv/fwicp_parse_checker.sv =====
module fwicp_parse_checker (
  input  logic        clk,
  input  logic        rst,
  fwicp_in_if         in_ch,
  fwicp_out_if        out_ch,
  output int          fail_count,
  output int          open_count
);

  typedef struct packed {
    logic                        kind;
    logic [2:0]                  status;
    logic [31:0]                 version;
    logic [fwicp_pkg::CNT_W-1:0] chunk_count;
    logic                        image_nonzero;
    logic [31:0]                 chunk_addr;
    logic [31:0]                 chunk_len;
    logic [31:0]                 chunk_offset;
  } reply_t;

  // Shadow parse state
  logic [fwicp_pkg::POS_W-1:0] img_pos;
  logic [31:0]                 word_sr;
  logic [31:0]                 img_version;
  logic [fwicp_pkg::CNT_W-1:0] declared_cnt;
  logic [fwicp_pkg::CNT_W-1:0] cursor;
  logic                        in_data;
  logic [2:0]                  hdr_cnt;
  logic [31:0]                 data_left;
  logic [2:0]                  parse_err;
  logic                        any_nonzero;
  logic [fwicp_pkg::CNT_W-1:0] valid_cnt;
  fwicp_pkg::chunk_entry_t     chunk_tbl [fwicp_pkg::MAX_CHUNKS];

  reply_t awaited_replies [$];
  reply_t want;

  function automatic void restart_stream();
    img_pos      = '0;
    word_sr      = '0;
    img_version  = '0;
    declared_cnt = '0;
    cursor       = '0;
    in_data      = 1'b0;
    hdr_cnt      = '0;
    data_left    = '0;
    parse_err    = fwicp_pkg::ST_OK;
    any_nonzero  = 1'b0;
  endfunction

  // Advance the parse by one image byte
  function automatic void absorb_image_byte(logic [7:0] b);
    logic [fwicp_pkg::POS_W-1:0] idx;
    idx = img_pos;
    if (idx == '0 && parse_err != fwicp_pkg::ST_TOO_LONG)
      valid_cnt = '0;
    if (b != 8'd0)
      any_nonzero = 1'b1;
    word_sr = {b, word_sr[31:8]};

    if (parse_err == fwicp_pkg::ST_OK) begin
      if (idx < fwicp_pkg::HDR_BYTES) begin
        if (idx == fwicp_pkg::POS_MAGIC && word_sr != fwicp_pkg::IMG_MAGIC)
          parse_err = fwicp_pkg::ST_MAGIC;
        else if (idx == fwicp_pkg::POS_VERSION)
          img_version = word_sr;
        else if (idx == fwicp_pkg::POS_COUNT) begin
          if (word_sr > 32'(fwicp_pkg::MAX_CHUNKS))
            parse_err = fwicp_pkg::ST_COUNT;
          else
            declared_cnt = word_sr[fwicp_pkg::CNT_W-1:0];
        end
      end else if (cursor < declared_cnt) begin
        if (in_data) begin
          data_left = data_left - 32'd1;
          if (data_left == 32'd0) begin
            in_data = 1'b0;
            cursor  = cursor + fwicp_pkg::CNT_W'(1);
          end
        end else begin
          if (hdr_cnt == fwicp_pkg::CHDR_OFFSET)
            chunk_tbl[cursor[fwicp_pkg::IDX_W-1:0]].offset = 32'(idx);
          if (hdr_cnt == fwicp_pkg::CHDR_ADDR)
            chunk_tbl[cursor[fwicp_pkg::IDX_W-1:0]].addr = word_sr;
          if (hdr_cnt == fwicp_pkg::CHDR_LAST) begin
            chunk_tbl[cursor[fwicp_pkg::IDX_W-1:0]].len = word_sr;
            hdr_cnt = '0;
            if (word_sr == 32'd0)
              cursor = cursor + fwicp_pkg::CNT_W'(1);
            else begin
              in_data   = 1'b1;
              data_left = word_sr;
            end
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
      end
    end

    // Wrap of the byte position marks the image as too long
    img_pos = idx + fwicp_pkg::POS_W'(1);
    if (img_pos == '0)
      parse_err = fwicp_pkg::ST_TOO_LONG;
  endfunction

  // Build the end-of-image report and start over
  function automatic reply_t close_image();
    reply_t r;
    logic [2:0] st;
    if (parse_err == fwicp_pkg::ST_TOO_LONG)
      st = fwicp_pkg::ST_TOO_LONG;
    else if (img_pos < fwicp_pkg::HDR_BYTES)
      st = fwicp_pkg::ST_SHORT;
    else if (parse_err != fwicp_pkg::ST_OK)
      st = parse_err;
    else if (cursor < declared_cnt)
      st = in_data ? fwicp_pkg::ST_DATA_TRUNC : fwicp_pkg::ST_HDR_TRUNC;
    else
      st = fwicp_pkg::ST_OK;

    valid_cnt       = (st == fwicp_pkg::ST_OK) ? declared_cnt : '0;
    r               = '0;
    r.kind          = fwicp_pkg::KIND_REPORT;
    r.status        = st;
    r.version       = (st == fwicp_pkg::ST_OK) ? img_version : 32'd0;
    r.chunk_count   = valid_cnt;
    r.image_nonzero = any_nonzero;
    restart_stream();
    return r;
  endfunction

  // Look up one chunk of the last good image
  function automatic reply_t answer_query(logic [7:0] idx);
    reply_t r;
    r             = '0;
    r.kind        = fwicp_pkg::KIND_QUERY;
    r.chunk_count = valid_cnt;
    if (idx < 8'(valid_cnt)) begin
      r.status       = fwicp_pkg::QST_OK;
      r.chunk_addr   = chunk_tbl[idx[fwicp_pkg::IDX_W-1:0]].addr;
      r.chunk_len    = chunk_tbl[idx[fwicp_pkg::IDX_W-1:0]].len;
      r.chunk_offset = chunk_tbl[idx[fwicp_pkg::IDX_W-1:0]].offset;
    end else begin
      r.status = fwicp_pkg::QST_BAD_INDEX;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // Compare results first, then predict from the item taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      restart_stream();
      valid_cnt = '0;
      awaited_replies.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got kind %0d status %0d",
                   $time, out_ch.kind, out_ch.status);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_ch.kind));
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("version", want.version, out_ch.version);
          check_field("chunk_count", 32'(want.chunk_count), 32'(out_ch.chunk_count));
          check_field("image_nonzero", 32'(want.image_nonzero), 32'(out_ch.image_nonzero));
          check_field("chunk_addr", want.chunk_addr, out_ch.chunk_addr);
          check_field("chunk_len", want.chunk_len, out_ch.chunk_len);
          check_field("chunk_offset", want.chunk_offset, out_ch.chunk_offset);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == fwicp_pkg::OP_QUERY)
          awaited_replies.push_back(answer_query(in_ch.chunk_index));
        else begin
          absorb_image_byte(in_ch.data_byte);
          if (in_ch.last)
            awaited_replies.push_back(close_image());
        end
      end
    end
    open_count = awaited_replies.size();
  end

endmodule

// ===== dv/firmware_image_chunk_parser_top_test.sv =====
module firmware_image_chunk_parser_top_test;

  localparam int ITEM_TARGET = 1350;
  localparam int QUIET_TAIL  = 250;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 120;

  typedef enum {
    IMG_GOOD, IMG_SHORT, IMG_BAD_MAGIC, IMG_BIG_COUNT,
    IMG_HDR_CUT, IMG_DATA_CUT, IMG_ZERO
  } image_shape_t;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   items_sent = 0;
  int   fail_count;
  int   open_count;
  int   chunks_declared;
  bit   sender_idles = 1'b1;
  bit   sink_idles = 1'b1;
  bit   hold_go = 1'b0;
  bit   hold_taken = 1'b0;
  logic [7:0] image_bytes [$];
  image_shape_t shape;

  fwicp_in_if  in_ch ();
  fwicp_out_if out_ch ();

  firmware_image_chunk_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fwicp_parse_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idles && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until taken
  task automatic offer(input logic op, input logic [7:0] b, input logic lst,
                       input logic [7:0] idx);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.data_byte   <= b;
    in_ch.last        <= lst;
    in_ch.chunk_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_query(input logic [7:0] idx);
    offer(fwicp_pkg::OP_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++)
      image_bytes.push_back(w[8*k +: 8]);
  endtask

  task automatic put_random_bytes(input int n);
    repeat (n) image_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Lay out one image; a negative count request picks one at random
  task automatic build_image(input image_shape_t kind, input int count_req);
    int n;
    int cut;
    int keep;
    int m;
    logic [31:0] len;
    image_bytes.delete();
    if (count_req >= 0)
      n = count_req;
    else if ($urandom_range(0, 9) == 0)
      n = $urandom_range(20, fwicp_pkg::MAX_CHUNKS);
    else
      n = $urandom_range(0, 5);
    if ((kind == IMG_HDR_CUT || kind == IMG_DATA_CUT) && n == 0)
      n = 1;
    chunks_declared = n;
    cut = (n > 0) ? $urandom_range(0, n - 1) : 0;

    // Header: magic, version, count, ignored total
    if (kind == IMG_BAD_MAGIC)
      put_word(fwicp_pkg::IMG_MAGIC ^ (32'd1 << $urandom_range(0, 31)));
    else
      put_word(fwicp_pkg::IMG_MAGIC);
    put_word($urandom);
    if (kind == IMG_BIG_COUNT) begin
      case ($urandom_range(0, 2))
        0:       put_word(32'(fwicp_pkg::MAX_CHUNKS + 1));
        1:       put_word(32'hFFFF_FFFF);
        default: put_word($urandom_range(fwicp_pkg::MAX_CHUNKS + 2, 100000));
      endcase
    end else begin
      put_word(32'(n));
    end
    put_word($urandom);

    // Chunks, cut short where the shape asks
    for (int i = 0; i < n; i++) begin
      if (kind == IMG_HDR_CUT && i == cut) begin
        put_random_bytes($urandom_range(0, 7));
        break;
      end
      put_word($urandom);
      if (kind == IMG_DATA_CUT && i == cut) begin
        len = $urandom_range(0, 1) ? 32'($urandom_range(1, 9)) : $urandom;
        if (len == 32'd0)
          len = 32'd1;
        m = (len > 32'd9) ? $urandom_range(0, 8) : $urandom_range(0, len - 1);
        put_word(len);
        put_random_bytes(m);
        break;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      put_word(len);
      put_random_bytes(len);
    end

    // Trailing bytes past the last chunk; short images are cut and zero images replaced
    if (kind == IMG_GOOD && $urandom_range(0, 3) == 0)
      put_random_bytes($urandom_range(1, 6));
    if (kind == IMG_SHORT) begin
      keep = $urandom_range(1, 15);
      while (image_bytes.size() > keep) void'(image_bytes.pop_back());
    end
    if (kind == IMG_ZERO) begin
      image_bytes.delete();
      repeat ($urandom_range(1, 24)) image_bytes.push_back(8'd0);
      chunks_declared = 0;
    end
  endtask

  // Stream the image, with an occasional query slipped in
  task automatic stream_image();
    foreach (image_bytes[i]) begin
      if ($urandom_range(0, 29) == 0)
        send_query(8'($urandom_range(0, 40)));
      offer(fwicp_pkg::OP_BYTE, image_bytes[i], i == image_bytes.size() - 1,
            8'($urandom_range(0, 255)));
    end
  endtask

  task automatic probe_chunks(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_query(8'($urandom_range(0, 255)));
      else
        send_query(8'($urandom_range(0, chunks_declared)));
    end
  endtask

  initial begin
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= fwicp_pkg::OP_BYTE;
    in_ch.data_byte    <= 8'd0;
    in_ch.last         <= 1'b0;
    in_ch.chunk_index  <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: query before any image, one-byte zero image, empty good image
    send_query(8'd0);
    offer(fwicp_pkg::OP_BYTE, 8'd0, 1'b1, 8'hFF);
    image_bytes.delete();
    put_word(fwicp_pkg::IMG_MAGIC);
    put_word(32'hFFFF_FFFF);
    put_word(32'd0);
    put_word(32'hFFFF_FFFF);
    chunks_declared = 0;
    stream_image();
    send_query(8'd0);
    send_query(8'hFF);

    // Full table first, then random shapes
    build_image(IMG_GOOD, fwicp_pkg::MAX_CHUNKS);
    stream_image();
    send_query(8'(fwicp_pkg::MAX_CHUNKS - 1));
    send_query(8'(fwicp_pkg::MAX_CHUNKS));
    probe_chunks(4);

    while (items_sent < ITEM_TARGET) begin
      sender_idles = $urandom_range(0, 3) != 0;
      sink_idles   = $urandom_range(0, 3) != 0;

      // Stall the result side and keep pushing items at the block
      if (!hold_go && items_sent > 450) begin
        hold_go      = 1'b1;
        sender_idles = 1'b0;
        repeat (24) send_query(8'($urandom_range(0, 40)));
      end

      if (items_sent > ITEM_TARGET - QUIET_TAIL) begin
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
      end

      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: shape = IMG_GOOD;
        10, 11:                       shape = IMG_SHORT;
        12:                           shape = IMG_BAD_MAGIC;
        13:                           shape = IMG_BIG_COUNT;
        14, 15:                       shape = IMG_HDR_CUT;
        16, 17:                       shape = IMG_DATA_CUT;
        default:                      shape = ($urandom_range(0, 1) != 0) ? IMG_ZERO : IMG_GOOD;
      endcase
      build_image(shape, -1);
      stream_image();
      probe_chunks($urandom_range(0, 4));
    end

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && open_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fwicp_pkg.sv
design/fwicp_in_if.sv
design/fwicp_out_if.sv
design/firmware_image_chunk_parser_top.sv
dv/fwicp_parse_checker.sv
dv/firmware_image_chunk_parser_top_test.sv
